### hdl/stl_pkg.sv
// Shared types, constants and register codes of the spiral tiling layout.
`default_nettype none
package stl_pkg;

  localparam int COORD_BITS = 14;
  localparam int GAP_BITS   = 8;
  localparam int MIN_BITS   = 11;
  localparam int HALF_BITS  = GAP_BITS - 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = COORD_BITS;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_GAP_SIZE      = 3'd2,
    REG_MIN_SIZE      = 3'd3,
    REG_SPIRAL_MODE   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_LEFT   = 2'd0,
    DIR_TOP    = 2'd1,
    DIR_RIGHT  = 2'd2,
    DIR_BOTTOM = 2'd3
  } dir_t;

  localparam coord_t              RST_SCREEN_WIDTH  = COORD_BITS'(1920);
  localparam coord_t              RST_SCREEN_HEIGHT = COORD_BITS'(1080);
  localparam logic [GAP_BITS-1:0] RST_GAP_SIZE      = GAP_BITS'(8);
  localparam logic [MIN_BITS-1:0] RST_MIN_SIZE      = MIN_BITS'(32);

  typedef struct packed {
    coord_t              screen_width;
    coord_t              screen_height;
    logic [GAP_BITS-1:0] gap_size;
    logic [MIN_BITS-1:0] min_size;
    logic                spiral_mode;
  } cfg_t;

  typedef struct packed {
    logic   is_first;
    logic   is_last;
    coord_t client_width;
    coord_t client_height;
  } item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  typedef struct packed {
    coord_t tile_x;
    coord_t tile_y;
    coord_t tile_w;
    coord_t tile_h;
    logic   needs_configure;
  } result_t;

endpackage
`default_nettype wire

### hdl/stl_cfg_regs.sv
// Configuration register file of the spiral tiling layout.
`default_nettype none
module stl_cfg_regs
  import stl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= RST_SCREEN_WIDTH;
      cfg.screen_height <= RST_SCREEN_HEIGHT;
      cfg.gap_size      <= RST_GAP_SIZE;
      cfg.min_size      <= RST_MIN_SIZE;
      cfg.spiral_mode   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[COORD_BITS-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[COORD_BITS-1:0];
        REG_GAP_SIZE:      cfg.gap_size      <= cfg_data[GAP_BITS-1:0];
        REG_MIN_SIZE:      cfg.min_size      <= cfg_data[MIN_BITS-1:0];
        REG_SPIRAL_MODE:   cfg.spiral_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/stl_split.sv
// Free rectangle state and the halving split that yields each window's cell.
`default_nettype none
module stl_split
  import stl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  advance,
  input  wire logic  is_first,
  input  wire logic  is_last,
  input  wire cfg_t  cfg,
  output rect_t      rect
);

  coord_t     free_x, free_y, free_w, free_h;
  logic [1:0] step_count;

  coord_t     free_x_next, free_y_next, free_w_next, free_h_next;
  coord_t     bx, by, bw, bh;
  logic [1:0] bstep;
  coord_t     half;
  coord_t     half_w, half_h;
  dir_t       dir;

  always_comb begin
    half = COORD_BITS'(cfg.gap_size >> 1);
    if (is_first) begin
      bx    = half;
      by    = half;
      bw    = (cfg.screen_width >= COORD_BITS'(cfg.gap_size))
              ? cfg.screen_width - COORD_BITS'(cfg.gap_size) : '0;
      bh    = (cfg.screen_height >= COORD_BITS'(cfg.gap_size))
              ? cfg.screen_height - COORD_BITS'(cfg.gap_size) : '0;
      bstep = 2'd0;
    end else begin
      bx    = free_x;
      by    = free_y;
      bw    = free_w;
      bh    = free_h;
      bstep = step_count;
    end
    half_w = bw >> 1;
    half_h = bh >> 1;
    dir    = cfg.spiral_mode ? dir_t'(bstep) : dir_t'({1'b0, bstep[0]});

    rect        = '{x: bx, y: by, w: bw, h: bh};
    free_x_next = bx;
    free_y_next = by;
    free_w_next = bw;
    free_h_next = bh;
    if (!is_last) begin
      unique case (dir)
        DIR_LEFT: begin
          rect.w      = half_w;
          free_x_next = bx + half_w;
          free_w_next = bw - half_w;
        end
        DIR_TOP: begin
          rect.h      = half_h;
          free_y_next = by + half_h;
          free_h_next = bh - half_h;
        end
        DIR_RIGHT: begin
          rect.w      = half_w;
          rect.x      = bx + (bw - half_w);
          free_w_next = bw - half_w;
        end
        DIR_BOTTOM: begin
          rect.h      = half_h;
          rect.y      = by + (bh - half_h);
          free_h_next = bh - half_h;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_x     <= '0;
      free_y     <= '0;
      free_w     <= '0;
      free_h     <= '0;
      step_count <= 2'd0;
    end else if (advance) begin
      free_x     <= free_x_next;
      free_y     <= free_y_next;
      free_w     <= free_w_next;
      free_h     <= free_h_next;
      step_count <= bstep + 2'd1;
    end
  end

endmodule
`default_nettype wire

### hdl/stl_cell.sv
// Gap inset, minimum clamp, saturation and size compare of one tile.
`default_nettype none
module stl_cell
  import stl_pkg::*;
(
  input  wire rect_t  rect,
  input  wire cfg_t   cfg,
  input  wire coord_t client_width,
  input  wire coord_t client_height,
  output result_t     result
);

  localparam logic [COORD_BITS:0] CoordMax = {1'b0, {COORD_BITS{1'b1}}};

  logic [HALF_BITS-1:0] half;
  logic [COORD_BITS:0]  sum_x, sum_y;
  logic [COORD_BITS:0]  gap_w, gap_h;
  logic [COORD_BITS:0]  minimum;
  coord_t               w_out, h_out;

  always_comb begin
    half    = cfg.gap_size[GAP_BITS-1:1];
    sum_x   = {1'b0, rect.x} + (COORD_BITS+1)'(half);
    sum_y   = {1'b0, rect.y} + (COORD_BITS+1)'(half);
    minimum = (cfg.min_size == '0) ? (COORD_BITS+1)'(1) : (COORD_BITS+1)'(cfg.min_size);
    gap_w   = {1'b0, rect.w} - (COORD_BITS+1)'(cfg.gap_size);
    gap_h   = {1'b0, rect.h} - (COORD_BITS+1)'(cfg.gap_size);
    w_out   = (rect.w >= COORD_BITS'(cfg.gap_size) && gap_w >= minimum)
              ? gap_w[COORD_BITS-1:0] : minimum[COORD_BITS-1:0];
    h_out   = (rect.h >= COORD_BITS'(cfg.gap_size) && gap_h >= minimum)
              ? gap_h[COORD_BITS-1:0] : minimum[COORD_BITS-1:0];

    result.tile_x          = (sum_x > CoordMax) ? CoordMax[COORD_BITS-1:0]
                                                : sum_x[COORD_BITS-1:0];
    result.tile_y          = (sum_y > CoordMax) ? CoordMax[COORD_BITS-1:0]
                                                : sum_y[COORD_BITS-1:0];
    result.tile_w          = w_out;
    result.tile_h          = h_out;
    result.needs_configure = (client_width != w_out) || (client_height != h_out);
  end

endmodule
`default_nettype wire

### hdl/spiral_tiling_layout.sv
// Top level of the spiral tiling layout: input stage, layout logic, result stage.
// Usage:
//   Input channel in_valid/in_stall carries one window per transaction, in map
//   order, flagged is_first at the start of a pass and is_last for the window
//   that takes the remaining area. Output channel out_valid/out_stall returns
//   one tile per window: position, size and the needs_configure flag.
//   Configuration via cfg_we/cfg_index/cfg_data is one register per write; the
//   user writes only while no transaction is in flight, unchecked by the block.
// Timing:
//   A transaction lands in the input register, and once the result stage is
//   ready the split and inset logic loads its tile into the result register
//   and raises out_valid. One transaction is accepted every cycle while the
//   result is not stalled; the free rectangle registers update on each advance.
// Reset:
//   rst clears both stages and the free rectangle and loads the register
//   defaults (1920x1080 screen, gap 8, minimum 32, spiral mode).
// Stall:
//   A stalled result holds; in_stall follows out_stall in the same cycle while
//   the input register is occupied and out_valid high; an empty one accepts.
`default_nettype none
module spiral_tiling_layout
  import stl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     is_first,
  input  wire logic                     is_last,
  input  wire logic [COORD_BITS-1:0]    client_width,
  input  wire logic [COORD_BITS-1:0]    client_height,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [COORD_BITS-1:0]         tile_x,
  output logic [COORD_BITS-1:0]         tile_y,
  output logic [COORD_BITS-1:0]         tile_w,
  output logic [COORD_BITS-1:0]         tile_h,
  output logic                          needs_configure
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  rect_t   rect;
  result_t result_next;
  result_t result;
  logic    res_ready;
  logic    advance;

  assign res_ready = !out_valid || !out_stall;
  assign advance   = item_valid && res_ready;
  assign in_stall  = item_valid && !res_ready;

  stl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= '{is_first: is_first, is_last: is_last,
                client_width: client_width, client_height: client_height};
    end
  end

  stl_split u_split (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .is_first (item.is_first),
    .is_last  (item.is_last),
    .cfg      (cfg),
    .rect     (rect)
  );

  stl_cell u_cell (
    .rect          (rect),
    .cfg           (cfg),
    .client_width  (item.client_width),
    .client_height (item.client_height),
    .result        (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign tile_x          = result.tile_x;
  assign tile_y          = result.tile_y;
  assign tile_w          = result.tile_w;
  assign tile_h          = result.tile_h;
  assign needs_configure = result.needs_configure;

endmodule
`default_nettype wire
